// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the downconverter, included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define IQDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is active
`define IQDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/iqdc_pkg.sv =====
// Package: constants, command/status types and sine ROM functions for the downconverter
`default_nettype none

package iqdc_pkg;

    // Defaults for top-level parameters
    localparam int MAX_DECIMATION_DEF  = 1024;
    localparam int FRAME_SAMPLES_DEF   = 8192;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int DEC_W      = 11;
    localparam int ALPHA_W    = 17;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int MIX_W      = 18;   // mixed sample, Q2.15
    localparam int LP_W       = 24;   // lowpass state, Q2.21
    localparam int AVG_QW     = 23;   // magnitude of averaged sample
    localparam int LEVEL_W    = 24;   // AGC level, Q0.24
    localparam int MAG_W      = 27;   // square root result
    localparam int SQ_W       = 55;   // square root radicand and work registers
    localparam int SQRT_ITERS = 27;
    localparam int OUT_QW     = 15;   // output quotient bits below saturation
    localparam int ITER_W     = 5;
    localparam int COEFF_W    = 26;
    localparam int SCALE_W    = 30;

    // AGC and output constants
    localparam int unsigned LEVEL_RESET = 167772;
    localparam int unsigned LEVEL_FLOOR = 168;
    localparam int unsigned LEVEL_MAX   = 16777215;
    localparam int unsigned ATTACK_Q32  = 42949673;
    localparam int unsigned RELEASE_Q32 = 858993;
    localparam int unsigned OUT_SCALE   = 966331597;  // 0.45 in Q0.16 times 32767
    localparam int unsigned ALPHA_ONE   = 65536;

    // Sine ROM build constants
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIMATION = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_LP_ALPHA   = 2'd2,
        CFG_INPUT_MODE = 2'd3
    } t_cfg_idx;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_I_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_Q_REAL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic acc;
        logic avg_step;
        logic lp_mul;
        logic lp_add;
        logic sq_mul;
        logic sq_init;
        logic sqrt_step;
        logic lv_mul;
        logic lv_add;
        logic o_mul;
        logic o_num;
        logic o_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dec_done;
    } t_sts;

    // Quarter-wave sine, degree-11 Taylor in Q2.30, scaled to 32767
    function automatic logic [15:0] quarter_sine(input int unsigned m, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (PI_HALF_Q30 * 64'(m)) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return v[15:0];
    endfunction

    // Full-turn sine ROM entry, mirrored from the quarter wave
    function automatic logic signed [15:0] sine_entry(input int k, input int bits);
        int unsigned quarter;
        int unsigned quad;
        int unsigned r;
        int unsigned m;
        logic [15:0] v;
        quarter = 1 << (bits - 2);
        quad    = k >> (bits - 2);
        r       = k & (quarter - 1);
        m       = ((quad & 1) != 0) ? quarter - r : r;
        v       = quarter_sine(m, bits);
        return ((quad & 2) != 0) ? -$signed(v) : $signed(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iqdc_ctrl.sv =====
// Controller: sequences one item through mix, average, lowpass, AGC and output division
`default_nettype none

module iqdc_ctrl #(
    parameter int FRAME_SAMPLES = iqdc_pkg::FRAME_SAMPLES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_frame_end,
    input  wire logic           i_cfg_we,
    output iqdc_pkg::t_cmd      o_cmd,
    input  iqdc_pkg::t_sts      i_sts
);
    import iqdc_pkg::*;

    localparam int FP_W = $clog2(FRAME_SAMPLES);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_AVG, S_LPMUL, S_LPADD, S_SQMUL, S_SQINIT,
        S_SQRT, S_LVMUL, S_LVADD, S_OMUL, S_ONUM, S_ODIV, S_OUT
    } t_state;

    t_state            r_state;
    logic [ITER_W-1:0] r_iter;
    logic              r_out_valid;
    logic              r_frame_end;
    logic [FP_W-1:0]   r_frame_pos;
    logic              w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_frame_end = r_frame_end;

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.clear     = i_cfg_we;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.avg_step  = (r_state == S_AVG);
        o_cmd.lp_mul    = (r_state == S_LPMUL);
        o_cmd.lp_add    = (r_state == S_LPADD);
        o_cmd.sq_mul    = (r_state == S_SQMUL);
        o_cmd.sq_init   = (r_state == S_SQINIT);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.lv_mul    = (r_state == S_LVMUL);
        o_cmd.lv_add    = (r_state == S_LVADD);
        o_cmd.o_mul     = (r_state == S_OMUL);
        o_cmd.o_num     = (r_state == S_ONUM);
        o_cmd.o_step    = (r_state == S_ODIV);
        o_cmd.out_load  = (r_state == S_OUT) && w_out_free;
    end

    // State, iteration count, output valid and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_frame_end <= 1'b0;
            r_frame_pos <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_iter  <= '0;
                    r_state <= i_sts.dec_done ? S_AVG : S_IDLE;
                end
                S_AVG: begin
                    if (r_iter == ITER_W'(AVG_QW - 1)) begin
                        r_state <= S_LPMUL;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_LPMUL: r_state <= S_LPADD;
                S_LPADD: r_state <= S_SQMUL;
                S_SQMUL: r_state <= S_SQINIT;
                S_SQINIT: begin
                    r_iter  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_iter == ITER_W'(SQRT_ITERS - 1)) begin
                        r_state <= S_LVMUL;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_LVMUL: r_state <= S_LVADD;
                S_LVADD: r_state <= S_OMUL;
                S_OMUL: r_state <= S_ONUM;
                S_ONUM: begin
                    r_iter  <= '0;
                    r_state <= S_ODIV;
                end
                S_ODIV: begin
                    if (r_iter == ITER_W'(OUT_QW - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_frame_pos >= FP_W'(FRAME_SAMPLES - 1)) begin
                            r_frame_end <= 1'b1;
                            r_frame_pos <= '0;
                        end else begin
                            r_frame_end <= 1'b0;
                            r_frame_pos <= r_frame_pos + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // register write restarts framing
            if (i_cfg_we) begin
                r_frame_pos <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/iqdc_dp.sv =====
// Datapath: NCO, mixer, averager, lowpass, AGC level, square root and dividers
`default_nettype none

module iqdc_dp #(
    parameter int MAX_DECIMATION  = iqdc_pkg::MAX_DECIMATION_DEF,
    parameter int SINE_TABLE_BITS = iqdc_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [iqdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [iqdc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic signed [iqdc_pkg::SAMPLE_W-1:0]  i_in_i,
    input  wire logic signed [iqdc_pkg::SAMPLE_W-1:0]  i_in_q,
    output logic signed [iqdc_pkg::SAMPLE_W-1:0]       o_out_i,
    output logic signed [iqdc_pkg::SAMPLE_W-1:0]       o_out_q,
    input  iqdc_pkg::t_cmd                             i_cmd,
    output iqdc_pkg::t_sts                             o_sts
);
    import iqdc_pkg::*;

    localparam int CNT_W     = $clog2(MAX_DECIMATION + 1);
    localparam int SUM_W     = MIX_W + $clog2(MAX_DECIMATION);
    localparam int AVG_W     = SUM_W + 6;
    localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
    localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int LPD_W     = LP_W + 1;
    localparam int LPP_W     = LPD_W + ALPHA_W + 1;
    localparam int LVD_W     = MAG_W + 2;
    localparam int LVP_W     = LVD_W + COEFF_W + 1;
    localparam int LVS_W     = LEVEL_W + 3;
    localparam int ON_W      = LP_W + SCALE_W;
    localparam int ONN_W     = ON_W - 13;
    localparam int ODV_W     = LEVEL_W + OUT_QW;

    // Configuration registers
    logic [DEC_W-1:0]   r_dec_factor;
    logic [PHASE_W-1:0] r_phase_step;
    logic [ALPHA_W-1:0] r_lp_alpha;
    logic [MODE_W-1:0]  r_input_mode;

    // Channel state
    logic [PHASE_W-1:0]      r_phase;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum [2];
    logic signed [LP_W-1:0]  r_lp  [2];
    logic [LEVEL_W-1:0]      r_level;

    // Work registers
    logic signed [SAMPLE_W-1:0] r_xi, r_xq, r_sin, r_cos;
    logic signed [PROD_W-1:0]   r_p_ic, r_p_qs, r_p_is, r_p_qc;
    logic [AVG_W-1:0]           r_avg_rem [2];
    logic [AVG_QW-1:0]          r_avg_quo [2];
    logic                       r_avg_neg [2];
    logic [AVG_W-1:0]           r_avg_dsh;
    logic signed [LPP_W-1:0]    r_lpp [2];
    logic signed [2*LP_W-1:0]   r_sq  [2];
    logic [SQ_W-1:0]            r_sv, r_res, r_bit;
    logic signed [LVP_W-1:0]    r_lvp;
    logic [ON_W-1:0]            r_on  [2];
    logic                       r_oneg [2];
    logic                       r_osat [2];
    logic [ODV_W-1:0]           r_orem [2];
    logic [OUT_QW-1:0]          r_oquo [2];
    logic [ODV_W-1:0]           r_odsh;
    logic signed [SAMPLE_W-1:0] r_out_i, r_out_q;

    // Combinational values
    logic signed [15:0]          w_rom [SINE_SIZE];
    logic [SINE_TABLE_BITS-1:0]  w_idx, w_idx_cos;
    logic signed [SAMPLE_W-1:0]  w_xi, w_xq;
    logic [CNT_W-1:0]            w_factor, w_cnt_n;
    logic [ALPHA_W-1:0]          w_alpha;
    logic                        w_done;
    logic signed [PROD_W:0]      w_mix_full [2];
    logic signed [MIX_W-1:0]     w_mix   [2];
    logic signed [SUM_W-1:0]     w_sum_n [2];
    logic [SUM_W-1:0]            w_sum_abs [2];
    logic signed [LPD_W-1:0]     w_avg [2];
    logic signed [LPD_W-1:0]     w_lpd [2];
    logic signed [LPP_W-1:0]     w_lp_rnd [2];
    logic signed [LP_W-1:0]      w_lp_n [2];
    logic [LP_W-1:0]             w_lp_abs [2];
    logic [SQ_W-1:0]             w_trial;
    logic [MAG_W-1:0]            w_mag;
    logic signed [LVD_W-1:0]     w_lvd;
    logic [COEFF_W-1:0]          w_coeff;
    logic signed [LVP_W-1:0]     w_lv_rnd;
    logic signed [LVS_W-1:0]     w_lv_sum;
    logic [LEVEL_W-1:0]          w_level_n;
    logic [ONN_W-1:0]            w_on_n [2];
    logic [SAMPLE_W-1:0]         w_omag [2];

    // Sine ROM contents
    for (genvar k = 0; k < SINE_SIZE; k++) begin : g_rom
        assign w_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    assign w_idx     = r_phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign w_idx_cos = w_idx + SINE_TABLE_BITS'(QUARTER);

    // Input mode selection
    always_comb begin
        case (r_input_mode)
            MODE_I_ONLY: begin
                w_xi = i_in_i;
                w_xq = '0;
            end
            MODE_Q_REAL: begin
                w_xi = i_in_q;
                w_xq = '0;
            end
            default: begin
                w_xi = i_in_i;
                w_xq = i_in_q;
            end
        endcase
    end

    // Effective decimation factor and lowpass coefficient
    always_comb begin
        if (r_dec_factor == '0) begin
            w_factor = CNT_W'(1);
        end else if (32'(r_dec_factor) > 32'(MAX_DECIMATION)) begin
            w_factor = CNT_W'(MAX_DECIMATION);
        end else begin
            w_factor = CNT_W'(r_dec_factor);
        end
        if (r_lp_alpha == '0) begin
            w_alpha = ALPHA_W'(1);
        end else if (r_lp_alpha > ALPHA_W'(ALPHA_ONE)) begin
            w_alpha = ALPHA_W'(ALPHA_ONE);
        end else begin
            w_alpha = r_lp_alpha;
        end
    end

    assign w_cnt_n      = r_cnt + CNT_W'(1);
    assign w_done       = (w_cnt_n >= w_factor);
    assign o_sts.dec_done = w_done;

    // Per-lane mixing, averaging and lowpass arithmetic
    always_comb begin
        w_mix_full[0] = (PROD_W+1)'(r_p_ic) - (PROD_W+1)'(r_p_qs) + (PROD_W+1)'(1 << 14);
        w_mix_full[1] = (PROD_W+1)'(r_p_is) + (PROD_W+1)'(r_p_qc) + (PROD_W+1)'(1 << 14);
        for (int l = 0; l < 2; l++) begin
            w_mix[l]     = MIX_W'(w_mix_full[l] >>> 15);
            w_sum_n[l]   = r_sum[l] + SUM_W'(w_mix[l]);
            w_sum_abs[l] = w_sum_n[l][SUM_W-1] ? SUM_W'(-w_sum_n[l]) : SUM_W'(w_sum_n[l]);
            w_avg[l]     = r_avg_neg[l] ? -$signed(LPD_W'(r_avg_quo[l]))
                                        : $signed(LPD_W'(r_avg_quo[l]));
            w_lpd[l]     = w_avg[l] - LPD_W'(r_lp[l]);
            w_lp_rnd[l]  = (r_lpp[l] + LPP_W'(1 << 15)) >>> 16;
            w_lp_n[l]    = r_lp[l] + LP_W'(w_lp_rnd[l]);
            w_lp_abs[l]  = r_lp[l][LP_W-1] ? LP_W'(-r_lp[l]) : LP_W'(r_lp[l]);
            w_on_n[l]    = ONN_W'((r_on[l] + ON_W'({r_level, 12'b0})) >> 13);
            w_omag[l]    = r_osat[l] ? SAMPLE_W'(32767) : {1'b0, r_oquo[l]};
        end
    end

    // AGC level update
    always_comb begin
        w_trial  = r_res + r_bit;
        w_mag    = r_res[MAG_W-1:0];
        w_lvd    = $signed({2'b0, w_mag}) - $signed({5'b0, r_level});
        w_coeff  = (w_mag > MAG_W'(r_level)) ? COEFF_W'(ATTACK_Q32) : COEFF_W'(RELEASE_Q32);
        w_lv_rnd = (r_lvp + LVP_W'(64'sh8000_0000)) >>> 32;
        w_lv_sum = $signed({3'b0, r_level}) + LVS_W'(w_lv_rnd);
        if (w_lv_sum < LVS_W'(LEVEL_FLOOR)) begin
            w_level_n = LEVEL_W'(LEVEL_FLOOR);
        end else if (w_lv_sum > LVS_W'(LEVEL_MAX)) begin
            w_level_n = LEVEL_W'(LEVEL_MAX);
        end else begin
            w_level_n = LEVEL_W'(w_lv_sum);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_factor <= DEC_W'(1);
            r_phase_step <= '0;
            r_lp_alpha   <= ALPHA_W'(ALPHA_ONE);
            r_input_mode <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DECIMATION: r_dec_factor <= i_cfg_data[DEC_W-1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_W-1:0];
                CFG_LP_ALPHA:   r_lp_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_INPUT_MODE: r_input_mode <= i_cfg_data[MODE_W-1:0];
                default:        r_input_mode <= r_input_mode;
            endcase
        end
    end

    // Channel state, cleared by reset and by any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_phase <= '0;
            r_cnt   <= '0;
            r_level <= LEVEL_W'(LEVEL_RESET);
            for (int l = 0; l < 2; l++) begin
                r_sum[l] <= '0;
                r_lp[l]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (i_cmd.acc) begin
                r_cnt <= w_done ? '0 : w_cnt_n;
                for (int l = 0; l < 2; l++) begin
                    r_sum[l] <= w_done ? '0 : w_sum_n[l];
                end
            end
            if (i_cmd.lp_add) begin
                for (int l = 0; l < 2; l++) begin
                    r_lp[l] <= w_lp_n[l];
                end
            end
            if (i_cmd.lv_add) begin
                r_level <= w_level_n;
            end
        end
    end

    // Sample capture, ROM read and mixer products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xi  <= w_xi;
            r_xq  <= w_xq;
            r_sin <= w_rom[w_idx];
            r_cos <= w_rom[w_idx_cos];
        end
        if (i_cmd.mul) begin
            r_p_ic <= r_xi * r_cos;
            r_p_qs <= r_xq * r_sin;
            r_p_is <= r_xi * r_sin;
            r_p_qc <= r_xq * r_cos;
        end
    end

    // Averaging divider: one quotient bit per step, both lanes
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && w_done) begin
            r_avg_dsh <= AVG_W'(w_cnt_n) << (AVG_QW - 1);
            for (int l = 0; l < 2; l++) begin
                r_avg_rem[l] <= {w_sum_abs[l], 6'b0} + AVG_W'(w_cnt_n >> 1);
                r_avg_quo[l] <= '0;
                r_avg_neg[l] <= w_sum_n[l][SUM_W-1];
            end
        end else if (i_cmd.avg_step) begin
            r_avg_dsh <= r_avg_dsh >> 1;
            for (int l = 0; l < 2; l++) begin
                if (r_avg_rem[l] >= r_avg_dsh) begin
                    r_avg_rem[l] <= r_avg_rem[l] - r_avg_dsh;
                    r_avg_quo[l] <= {r_avg_quo[l][AVG_QW-2:0], 1'b1};
                end else begin
                    r_avg_quo[l] <= {r_avg_quo[l][AVG_QW-2:0], 1'b0};
                end
            end
        end
    end

    // Lowpass product and squares for the magnitude
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.lp_mul) begin
                r_lpp[l] <= w_lpd[l] * $signed({1'b0, w_alpha});
            end
            if (i_cmd.sq_mul) begin
                r_sq[l] <= r_lp[l] * r_lp[l];
            end
        end
    end

    // Square root: one result bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_sv  <= (SQ_W'(r_sq[0][2*LP_W-2:0]) + SQ_W'(r_sq[1][2*LP_W-2:0])) << 6;
            r_res <= '0;
            r_bit <= SQ_W'(1) << (2 * (SQRT_ITERS - 1));
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= w_trial) begin
                r_sv  <= r_sv - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Level product, output scaling and output divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.lv_mul) begin
            r_lvp <= w_lvd * $signed({1'b0, w_coeff});
        end
        if (i_cmd.o_num) begin
            r_odsh <= ODV_W'({r_level, 14'b0});
        end else if (i_cmd.o_step) begin
            r_odsh <= r_odsh >> 1;
        end
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.o_mul) begin
                r_on[l]   <= ON_W'(w_lp_abs[l]) * ON_W'(OUT_SCALE);
                r_oneg[l] <= r_lp[l][LP_W-1];
            end
            if (i_cmd.o_num) begin
                r_osat[l] <= (w_on_n[l] >= ONN_W'({r_level, 15'b0}));
                r_orem[l] <= ODV_W'(w_on_n[l]);
                r_oquo[l] <= '0;
            end else if (i_cmd.o_step) begin
                if (r_orem[l] >= r_odsh) begin
                    r_orem[l] <= r_orem[l] - r_odsh;
                    r_oquo[l] <= {r_oquo[l][OUT_QW-2:0], 1'b1};
                end else begin
                    r_oquo[l] <= {r_oquo[l][OUT_QW-2:0], 1'b0};
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_i <= r_oneg[0] ? -$signed(w_omag[0]) : $signed(w_omag[0]);
            r_out_q <= r_oneg[1] ? -$signed(w_omag[1]) : $signed(w_omag[1]);
        end
    end

    assign o_out_i = r_out_i;
    assign o_out_q = r_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/iq_channel_downconverter_agc_top.sv =====
// Top level: I/Q channel downconverter with decimation, lowpass and AGC
//
// Input stream: one complex sample per item, s_axis_tdata = {in_q, in_i}.
// Output stream: one gain-controlled sample per decimation_factor input items,
// m_axis_tdata = {out_q, out_i}, m_axis_tlast marks the last sample of each frame.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 decimation, 1 phase step, 2 lowpass alpha, 3 input mode); any write
// clears the NCO, averager, lowpass, AGC level and frame position.
// Throughput: one item at a time. An item that completes no average passes
// through ROM read, multiply and accumulate. An item that completes an
// average also passes through a 23-step averaging divider, 27-step square
// root and 15-step output divider, with multiply and add steps between.
// The output register holds one result; the next item is accepted while it
// waits, and a new result stalls only until the receiver takes the old one.
// Reset (synchronous, active low) loads register defaults and clears state.
`default_nettype none

`include "assert_macros.svh"

module iq_channel_downconverter_agc_top #(
    parameter int MAX_DECIMATION  = iqdc_pkg::MAX_DECIMATION_DEF,
    parameter int FRAME_SAMPLES   = iqdc_pkg::FRAME_SAMPLES_DEF,
    parameter int SINE_TABLE_BITS = iqdc_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [31:0]                       s_axis_tdata,   // in_i, in_q
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [31:0]                            m_axis_tdata,   // out_i, out_q
    output logic                                   m_axis_tlast,   // frame_end
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [iqdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [iqdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import iqdc_pkg::*;

    t_cmd                       w_cmd;
    t_sts                       w_sts;
    logic signed [SAMPLE_W-1:0] w_out_i, w_out_q;

    iqdc_ctrl #(
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_frame_end (m_axis_tlast),
        .i_cfg_we    (i_cfg_wr_en),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    iqdc_dp #(
        .MAX_DECIMATION  (MAX_DECIMATION),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_i      (s_axis_tdata[SAMPLE_W-1:0]),
        .i_in_q      (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .o_out_i     (w_out_i),
        .o_out_q     (w_out_q),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign m_axis_tdata = {w_out_q, w_out_i};

    // One item in flight: the input side closes right after an accept
    `IQDC_ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A new result is loaded only when the output register is free
    `IQDC_ASSERT_IMPL(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_load, !m_axis_tvalid || m_axis_tready)

endmodule

`default_nettype wire
